// File: hw/rtl/gcrm_pkg.sv
// shared types, codes and constants of the gated clock ratio meter
package gcrm_pkg;

    localparam int DIV_W   = 84;   // dividend and quotient width of the divider
    localparam int DVS_W   = 64;   // divisor and remainder width
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_TOP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_HZ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_HZ   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd6;

    localparam logic [31:0] MS_SCALE  = 32'd1000;
    localparam logic [31:0] PPM_SCALE = 32'd1000000;

    typedef struct packed {
        logic        op;
        logic [31:0] lf;
        logic [31:0] hf;
        logic [47:0] up;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] sspan;
        logic [31:0] fspan;
        logic [31:0] freq;
        logic [31:0] ppm;
        logic        floor;
    } t_res;

endpackage

// File: hw/rtl/gcrm_front.sv
// input queue: accepts sample and start transactions ahead of the sequencer
module gcrm_front import gcrm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// File: hw/rtl/gcrm_div.sv
// restoring divider, one quotient bit per cycle
module gcrm_div import gcrm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);
    logic              r_busy, r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem, r_dvs;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W:0]    trial, diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: hw/rtl/gcrm_resq.sv
// result queue: holds finished results until popped
module gcrm_resq import gcrm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);
    t_res       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// File: hw/rtl/gcrm_back.sv
// measurement sequencer: window state, config registers, shared multiplier
module gcrm_back import gcrm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_res_push,
    output t_res                 o_res,
    input  logic                 i_res_full
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_DLMUL = 4'd2;
    localparam logic [3:0] S_DLGO  = 4'd3;
    localparam logic [3:0] S_DLWT  = 4'd4;
    localparam logic [3:0] S_SPAN  = 4'd5;
    localparam logic [3:0] S_FQGO  = 4'd6;
    localparam logic [3:0] S_FQWT  = 4'd7;
    localparam logic [3:0] S_EXGO  = 4'd8;
    localparam logic [3:0] S_EXWT  = 4'd9;
    localparam logic [3:0] S_PMLO  = 4'd10;
    localparam logic [3:0] S_PMHI  = 4'd11;
    localparam logic [3:0] S_MGGO  = 4'd12;
    localparam logic [3:0] S_MGWT  = 4'd13;
    localparam logic [3:0] S_EMIT  = 4'd14;

    logic [31:0] r_gate, r_stop, r_ftop, r_ref;
    logic [23:0] r_nom;
    logic [15:0] r_margin;
    logic [19:0] r_floor;

    logic [31:0] r_sstart, r_fstart;
    logic [48:0] r_deadline;
    logic        r_open;

    logic [3:0]       r_state;
    t_item            r_item;
    logic [DIV_W-1:0] r_acc;
    logic [63:0]      r_prod, r_exp, r_a;
    logic [31:0]      r_sspan, r_fspan, r_freq;
    logic             r_pos;
    t_res             r_res;

    logic [23:0]      nom1;
    logic [31:0]      sspan, fspan;
    logic [32:0]      swrap, fwrap;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;
    logic [49:0]      dl_sum;
    logic [31:0]      ppm;

    assign nom1 = (r_nom == 24'd0) ? 24'd1 : r_nom;

    // spans modulo top+1, truncated to 32 bits
    assign swrap = {1'b0, r_item.lf} + {1'b0, r_stop} + 33'd1 - {1'b0, r_sstart};
    assign fwrap = {1'b0, r_item.hf} + {1'b0, r_ftop} + 33'd1 - {1'b0, r_fstart};
    assign sspan = (r_item.lf >= r_sstart) ? r_item.lf - r_sstart : swrap[31:0];
    assign fspan = (r_item.hf >= r_fstart) ? r_item.hf - r_fstart : fwrap[31:0];

    always_comb begin
        case (r_state)
            S_DLMUL: begin mul_a = r_gate;     mul_b = MS_SCALE;  end
            S_SPAN:  begin mul_a = r_sspan;    mul_b = r_ref;     end
            S_PMLO:  begin mul_a = r_a[31:0];  mul_b = PPM_SCALE; end
            S_PMHI:  begin mul_a = r_a[63:32]; mul_b = PPM_SCALE; end
            default: begin mul_a = 32'd0;      mul_b = 32'd0;     end
        endcase
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_acc;
        div_dvs   = {40'd0, nom1};
        case (r_state)
            S_DLGO: div_start = 1'b1;
            S_FQGO: begin
                div_start = 1'b1;
                div_dvd   = {20'd0, r_prod};
                div_dvs   = {32'd0, r_fspan};
            end
            S_EXGO: begin
                div_start = 1'b1;
                div_dvd   = {20'd0, r_prod};
            end
            S_MGGO: begin
                div_start = 1'b1;
                div_dvs   = r_exp;
            end
            default: div_start = 1'b0;
        endcase
    end

    gcrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign dl_sum = {2'd0, r_item.up} + {1'b0, div_q[48:0]} + {34'd0, r_margin};

    // saturated signed ppm from the magnitude
    always_comb begin
        if (r_pos) begin
            ppm = (div_q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
        end else begin
            ppm = (div_q > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'd0 - div_q[31:0];
        end
    end

    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_res_push = (r_state == S_EMIT) && !i_res_full;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate   <= 32'd32768;
            r_stop   <= 32'hFFFF_FFFF;
            r_ftop   <= 32'hFFFF_FFFF;
            r_ref    <= 32'd16000000;
            r_nom    <= 24'd32768;
            r_margin <= 16'd100;
            r_floor  <= 20'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GATE:     r_gate   <= i_cfg_data;
                CFG_SLOW_TOP: r_stop   <= i_cfg_data;
                CFG_FAST_TOP: r_ftop   <= i_cfg_data;
                CFG_REF_HZ:   r_ref    <= i_cfg_data;
                CFG_NOM_HZ:   r_nom    <= i_cfg_data[23:0];
                CFG_MARGIN:   r_margin <= i_cfg_data[15:0];
                CFG_FLOOR:    r_floor  <= i_cfg_data[19:0];
                default:      r_gate   <= r_gate;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_open     <= 1'b0;
            r_sstart   <= 32'd0;
            r_fstart   <= 32'd0;
            r_deadline <= 49'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item  <= i_q_item;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    if (r_item.op == OP_START) begin
                        r_state <= S_DLMUL;
                    end else if (!r_open) begin
                        r_state <= S_IDLE;
                    end else if ({1'b0, r_item.up} > r_deadline) begin
                        r_open  <= 1'b0;
                        r_res   <= '{STATUS_TIMEOUT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0};
                        r_state <= S_EMIT;
                    end else if (sspan < r_gate) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_open  <= 1'b0;
                        r_sspan <= sspan;
                        r_fspan <= fspan;
                        r_state <= S_SPAN;
                    end
                end
                S_DLMUL: begin
                    r_acc   <= {20'd0, mul_p};
                    r_state <= S_DLGO;
                end
                S_DLGO: r_state <= S_DLWT;
                S_DLWT: begin
                    if (div_done) begin
                        r_deadline <= dl_sum[48:0];
                        r_sstart   <= r_item.lf;
                        r_fstart   <= r_item.hf;
                        r_open     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_SPAN: begin
                    if (r_fspan == 32'd0) begin
                        r_res   <= '{STATUS_INVALID, r_sspan, r_fspan, 32'd0, 32'd0, 1'b0};
                        r_state <= S_EMIT;
                    end else begin
                        r_prod  <= mul_p;
                        r_state <= S_FQGO;
                    end
                end
                S_FQGO: r_state <= S_FQWT;
                S_FQWT: begin
                    if (div_done) begin
                        r_freq  <= div_q[31:0];
                        r_state <= S_EXGO;
                    end
                end
                S_EXGO: r_state <= S_EXWT;
                S_EXWT: begin
                    if (div_done) begin
                        r_exp <= div_q[63:0];
                        r_pos <= (div_q[63:0] >= {32'd0, r_fspan});
                        r_a   <= (div_q[63:0] >= {32'd0, r_fspan})
                               ? div_q[63:0] - {32'd0, r_fspan}
                               : {32'd0, r_fspan} - div_q[63:0];
                        if (div_q[63:0] == 64'd0) begin
                            r_res   <= '{STATUS_INVALID, r_sspan, r_fspan, r_freq, 32'd0, 1'b0};
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_PMLO;
                        end
                    end
                end
                S_PMLO: begin
                    r_acc   <= {20'd0, mul_p};
                    r_state <= S_PMHI;
                end
                S_PMHI: begin
                    r_acc   <= r_acc + {mul_p[51:0], 32'd0};
                    r_state <= S_MGGO;
                end
                S_MGGO: r_state <= S_MGWT;
                S_MGWT: begin
                    if (div_done) begin
                        r_res   <= '{STATUS_OK, r_sspan, r_fspan, r_freq, ppm,
                                     div_q > {64'd0, r_floor}};
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!i_res_full) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/gated_clock_ratio_meter.sv
// top level of the gated clock ratio meter
// reciprocal frequency meter for a slow clock polled against a fast reference
// counter. a start transaction (operation 0) captures both counters and arms a
// deadline; a poll transaction (operation 1) is dropped when no window is open;
// else it times out, is dropped while the slow span is short of the gate
// length, or closes the window and yields one result. transactions enter a
// two-entry input queue and results leave through a two-entry result queue, so
// both sides stall independently. transactions are handled one at a time by the
// single sequencer and its shared bit-serial divider; the next is popped only
// when the sequencer is idle. a start takes one division, and a closing poll
// takes three divisions plus multiplies.
module gated_clock_ratio_meter import gcrm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    // sample transactions
    input  logic                 push,
    output logic                 full,
    input  logic                 i_operation,
    input  logic [31:0]          i_lf_count,
    input  logic [31:0]          i_hf_count,
    input  logic [47:0]          i_uptime_ms,
    // result transactions
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           o_status,
    output logic [31:0]          o_slow_span,
    output logic [31:0]          o_fast_span,
    output logic [31:0]          o_slow_freq_hz,
    output logic signed [31:0]   o_ppm_error,
    output logic                 o_outside_floor
);
    t_item in_item, q_item;
    t_res  bk_res, out_res;
    logic  q_valid, q_pop, res_push, res_full;

    assign in_item = '{i_operation, i_lf_count, i_hf_count, i_uptime_ms};

    // front: input queue
    gcrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: window state and arithmetic
    gcrm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_res_push (res_push),
        .o_res      (bk_res),
        .i_res_full (res_full)
    );

    // results wait here until popped
    gcrm_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (bk_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (out_res)
    );

    assign o_status        = out_res.status;
    assign o_slow_span     = out_res.sspan;
    assign o_fast_span     = out_res.fspan;
    assign o_slow_freq_hz  = out_res.freq;
    assign o_ppm_error     = out_res.ppm;
    assign o_outside_floor = out_res.floor;
endmodule

// File: hw/rtl/gcrm_check.sv
// port-level assertions for the gated clock ratio meter, bound to the top level
module gcrm_check import gcrm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_status,
    input logic [31:0] o_slow_span,
    input logic [31:0] o_fast_span,
    input logic [31:0] o_slow_freq_hz,
    input logic [31:0] o_ppm_error,
    input logic        o_outside_floor
);
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == STATUS_OK || o_status == STATUS_TIMEOUT
                    || o_status == STATUS_INVALID))
        else $error("bad status code");

    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STATUS_TIMEOUT) |->
        (o_slow_span == 32'd0 && o_fast_span == 32'd0 && o_slow_freq_hz == 32'd0
         && o_ppm_error == 32'd0 && !o_outside_floor))
        else $error("timeout result carries data");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == STATUS_INVALID) |->
        (o_ppm_error == 32'd0 && !o_outside_floor))
        else $error("invalid result carries ppm");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_ppm_error)))
        else $error("waiting result changed");
endmodule

bind gated_clock_ratio_meter gcrm_check u_check (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the gated clock ratio meter
`timescale 1ns / 100ps

module testbench;
    import gcrm_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_operation = 1'b0;
    logic [31:0]          i_lf_count = '0;
    logic [31:0]          i_hf_count = '0;
    logic [47:0]          i_uptime_ms = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [1:0]           o_status;
    logic [31:0]          o_slow_span;
    logic [31:0]          o_fast_span;
    logic [31:0]          o_slow_freq_hz;
    logic signed [31:0]   o_ppm_error;
    logic                 o_outside_floor;

    gated_clock_ratio_meter dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shared bookkeeping
    // ------------------------------------------------------------------
    t_item pending_items[$];     // samples waiting to be offered
    t_res  expected_results[$];  // results owed by the block, oldest first
    t_item offered_item;         // transaction currently on the input ports
    int    error_count = 0;
    bit    quiet = 1'b0;         // no idling on either side
    int    hold_request = 0;     // long receiver hold-off, in cycles

    // mirror of the configuration registers
    logic [31:0] cfg_gate   = 32'd32768;
    logic [31:0] cfg_stop   = 32'hFFFF_FFFF;
    logic [31:0] cfg_ftop   = 32'hFFFF_FFFF;
    logic [31:0] cfg_ref    = 32'd16000000;
    logic [23:0] cfg_nom    = 24'd32768;
    logic [15:0] cfg_margin = 16'd100;
    logic [19:0] cfg_floor  = 20'd100;

    // window state of the predictor
    logic [31:0] win_slow_start = '0;
    logic [31:0] win_fast_start = '0;
    logic [48:0] win_deadline = '0;
    bit          win_open = 1'b0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] modular_span(logic [31:0] top, logic [31:0] from,
                                                 logic [31:0] to);
        if (to >= from) return to - from;
        return 32'(64'(to) + 64'(top) + 64'd1 - 64'(from));
    endfunction

    function automatic void predict_measurement(t_item it);
        logic [63:0]  nom;
        logic [63:0]  prod;
        logic [63:0]  expct;
        logic [63:0]  diff;
        logic [127:0] scaled;
        logic [63:0]  mag;
        logic [31:0]  sspan;
        logic [31:0]  fspan;
        t_res         r;
        nom = (cfg_nom == 0) ? 64'd1 : 64'(cfg_nom);
        r = '0;
        if (it.op == OP_START) begin
            win_slow_start = it.lf;
            win_fast_start = it.hf;
            win_deadline = 49'(64'(it.up) + (64'(cfg_gate) * 64'(MS_SCALE)) / nom
                               + 64'(cfg_margin));
            win_open = 1'b1;
            return;
        end
        if (!win_open) return;      // poll with no window: dropped
        if (49'(it.up) > win_deadline) begin
            win_open = 1'b0;
            r.status = STATUS_TIMEOUT;
            expected_results.push_back(r);
            return;
        end
        sspan = modular_span(cfg_stop, win_slow_start, it.lf);
        if (sspan < cfg_gate) return;   // window still short
        win_open = 1'b0;
        fspan = modular_span(cfg_ftop, win_fast_start, it.hf);
        r.sspan = sspan;
        r.fspan = fspan;
        if (fspan == 0) begin
            r.status = STATUS_INVALID;  // stalled reference
            expected_results.push_back(r);
            return;
        end
        prod = 64'(sspan) * 64'(cfg_ref);
        r.freq = 32'(prod / 64'(fspan));
        expct = prod / nom;
        if (expct == 0) begin
            r.status = STATUS_INVALID;  // nothing expected to compare with
            expected_results.push_back(r);
            return;
        end
        diff = (expct >= 64'(fspan)) ? expct - 64'(fspan) : 64'(fspan) - expct;
        scaled = (128'(diff) * 128'(PPM_SCALE)) / 128'(expct);
        mag = scaled[63:0];
        if (expct >= 64'(fspan))
            r.ppm = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        else
            r.ppm = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        r.floor = (mag > 64'(cfg_floor));
        r.status = STATUS_OK;
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers pending samples, with random idle bursts
    // ------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) predict_measurement(offered_item);
            if (!(push && full)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    push <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    offered_item = pending_items.pop_front();
                    i_operation <= offered_item.op;
                    i_lf_count  <= offered_item.lf;
                    i_hf_count  <= offered_item.hf;
                    i_uptime_ms <= offered_item.up;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: takes results, with random stalls and one long hold-off
    // ------------------------------------------------------------------
    int recv_gap = 0;
    int recv_hold = 0;
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction, status %0d", o_status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_slow_span !== want.sspan) begin
                        $error("slow_span: expected %0d, got %0d", want.sspan, o_slow_span);
                        error_count++;
                    end
                    if (o_fast_span !== want.fspan) begin
                        $error("fast_span: expected %0d, got %0d", want.fspan, o_fast_span);
                        error_count++;
                    end
                    if (o_slow_freq_hz !== want.freq) begin
                        $error("slow_freq_hz: expected %0d, got %0d", want.freq,
                               o_slow_freq_hz);
                        error_count++;
                    end
                    if (o_ppm_error !== $signed(want.ppm)) begin
                        $error("ppm_error: expected %0d, got %0d", $signed(want.ppm),
                               o_ppm_error);
                        error_count++;
                    end
                    if (o_outside_floor !== want.floor) begin
                        $error("outside_floor: expected %0d, got %0d", want.floor,
                               o_outside_floor);
                        error_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                recv_hold = hold_request;
                hold_request = 0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(1, 14) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_item mk(logic op, logic [31:0] lf, logic [31:0] hf, logic [47:0] up);
        t_item it;
        it.op = op;
        it.lf = lf;
        it.hf = hf;
        it.up = up;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // wait until the block has drained, then past its longest busy stretch
    task automatic wait_drained();
        while (pending_items.size() > 0 || push || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
    endtask

    task automatic set_config(logic [31:0] g, logic [31:0] st, logic [31:0] ft,
                              logic [31:0] rf, logic [23:0] nm, logic [15:0] mg,
                              logic [19:0] fl);
        write_reg(CFG_GATE, g);
        write_reg(CFG_SLOW_TOP, st);
        write_reg(CFG_FAST_TOP, ft);
        write_reg(CFG_REF_HZ, rf);
        write_reg(CFG_NOM_HZ, 32'(nm));
        write_reg(CFG_MARGIN, 32'(mg));
        write_reg(CFG_FLOOR, 32'(fl));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_gate = g;
        cfg_stop = st;
        cfg_ftop = ft;
        cfg_ref = rf;
        cfg_nom = nm;
        cfg_margin = mg;
        cfg_floor = fl;
    endtask

    // one window: a start, some short polls, then a close, a timeout or a stall
    task automatic add_window();
        logic [31:0] lf0;
        logic [31:0] hf0;
        logic [47:0] up0;
        logic [63:0] nomg;
        logic [63:0] dlen;
        logic [63:0] est;
        longint      jit;
        int          polls;
        int          kind;
        lf0 = $urandom;
        hf0 = $urandom;
        up0 = 48'(rand64() >> ($urandom_range(0, 1) ? 16 : 24));
        nomg = (cfg_nom == 0) ? 64'd1 : 64'(cfg_nom);
        dlen = (64'(cfg_gate) * 64'(MS_SCALE)) / nomg + 64'(cfg_margin);
        pending_items.push_back(mk(OP_START, lf0, hf0, up0));
        polls = (cfg_gate > 1) ? $urandom_range(0, 3) : 0;
        repeat (polls)
            pending_items.push_back(mk(OP_SAMPLE, lf0 + ($urandom % cfg_gate), $urandom,
                                       up0 + 48'(rand64() % (dlen + 1))));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            pending_items.push_back(mk(OP_SAMPLE, $urandom, $urandom,
                                       up0 + 48'(dlen) + 48'($urandom_range(1, 50))));
        end else begin
            est = (64'(cfg_gate) * 64'(cfg_ref)) / nomg;
            jit = longint'($urandom_range(0, 2000)) - 1000;
            est = 64'(longint'(est) + jit * longint'(est / 64'd100000));
            pending_items.push_back(mk(OP_SAMPLE, lf0 + cfg_gate + $urandom_range(0, 3),
                                       (kind == 1) ? hf0 : hf0 + 32'(est),
                                       up0 + 48'(rand64() % (dlen + 1))));
        end
    endtask

    // a phase of mostly well-formed windows with some noise mixed in
    task automatic add_phase(int count);
        int start_size;
        start_size = pending_items.size();
        while (pending_items.size() - start_size < count) begin
            if ($urandom_range(0, 6) == 0)
                pending_items.push_back(mk(logic'($urandom_range(0, 1)), $urandom, $urandom,
                                           48'(rand64())));
            else
                add_window();
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset defaults
        pending_items.push_back(mk(OP_SAMPLE, 32'd40000, 32'd5, 48'd3));  // no window yet
        pending_items.push_back(mk(OP_START, 32'd0, 32'd0, 48'd0));
        pending_items.push_back(mk(OP_START, 32'd100, 32'd5, 48'd10));    // restart
        pending_items.push_back(mk(OP_SAMPLE, 32'd200, 32'd99, 48'd20));  // short span
        pending_items.push_back(mk(OP_SAMPLE, 32'd32868, 32'd16000005, 48'd500));
        pending_items.push_back(mk(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd1000));
        pending_items.push_back(mk(OP_SAMPLE, 32'd32767, 32'hFFFF_FFFF, 48'd1000));
        pending_items.push_back(mk(OP_START, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF));
        pending_items.push_back(mk(OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   48'hFFFF_FFFF_FFFF));
        pending_items.push_back(mk(OP_START, 32'd0, 32'd0, 48'd0));
        pending_items.push_back(mk(OP_SAMPLE, 32'd1, 32'd1, 48'd1101));   // past deadline
        pending_items.push_back(mk(OP_START, 32'd7, 32'd9, 48'd50));
        pending_items.push_back(mk(OP_SAMPLE, 32'd32775, 32'd16160009, 48'd60));
        pending_items.push_back(mk(OP_START, 32'd7, 32'd9, 48'd50));
        pending_items.push_back(mk(OP_SAMPLE, 32'd32775, 32'd15990009, 48'd1150));
        wait_drained();

        // smallest values: tops of one, counters above their top
        set_config(32'd1, 32'd1, 32'd1, 32'd1, 24'd1, 16'd0, 20'd0);
        pending_items.push_back(mk(OP_START, 32'd5, 32'd0, 48'd0));
        pending_items.push_back(mk(OP_SAMPLE, 32'd2, 32'hFFFF_FFFF, 48'd1));
        pending_items.push_back(mk(OP_START, 32'd0, 32'd3, 48'd0));
        pending_items.push_back(mk(OP_SAMPLE, 32'd1, 32'd3, 48'd1));      // stalled
        add_phase(70);
        wait_drained();

        // no expected count: nominal far above span times reference
        set_config(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 24'hFF_FFFF, 16'd65535,
                   20'd1000000);
        pending_items.push_back(mk(OP_START, 32'd0, 32'd0, 48'd0));
        pending_items.push_back(mk(OP_SAMPLE, 32'd5, 32'd2, 48'd0));
        hold_request = 3000;   // results back up, input queue fills and stalls
        add_phase(70);
        wait_drained();

        // largest values
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   24'hFF_FFFF, 16'd65535, 20'd1000000);
        add_phase(70);
        wait_drained();

        // zero nominal is taken as one
        set_config(32'd1000, 32'd99999, 32'd15999999, 32'd16000000, 24'd0, 16'd5, 20'd50);
        add_phase(70);
        wait_drained();

        // random settings, small gates mostly
        repeat (8) begin
            set_config($urandom_range(1, 5000), $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom,
                       $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom,
                       $urandom_range(1000, 64000000), 24'($urandom_range(1, 24'hFF_FFFF)),
                       16'($urandom), 20'($urandom_range(0, 1000000)));
            add_phase(75);
            wait_drained();
        end

        // final stretch with both sides always ready
        quiet = 1'b1;
        set_config(32'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16000000, 24'd32768,
                   16'd100, 20'd100);
        add_phase(60);
        wait_drained();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far beyond the slowest passing run
    initial begin
        #60ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
